>>> hw/rtl/nfs_pkg.sv
// Shared types and constants for the nearest free slot search block.
// Used by nfs_ctrl, nfs_dp and nearest_free_slot_search; no dependencies.
package nfs_pkg;

	localparam int MAX_SLOTS_DEF = 4096;
	localparam int WORD_W        = 64;
	localparam int BIT_W         = 6;
	localparam int WIDX_W        = 6;
	localparam int SLOT_W        = 12;
	localparam int CNT_W         = 13;

	typedef enum logic [1:0] {
		KIND_LOAD_REMOVED = 2'd0,
		KIND_LOAD_USED    = 2'd1,
		KIND_QUERY        = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SEARCH,
		ST_DONE
	} state_t;

	typedef struct packed {
		kind_t               kind;
		logic [WIDX_W-1:0]   word_index;
		logic [WORD_W-1:0]   word_data;
		logic [SLOT_W-1:0]   middle_index;
	} in_t;

	typedef struct packed {
		logic                found;
		logic [SLOT_W-1:0]   slot_index;
	} out_t;

	typedef struct packed {
		logic clear;
		logic load_removed;
		logic load_used;
		logic start;
		logic step;
		logic capture;
		logic push;
	} cmd_t;

	typedef struct packed {
		logic clear_last;
		logic done;
	} status_t;

endpackage

>>> hw/rtl/nearest_free_slot_search.sv
// Nearest free slot search. Two bitmaps of 64-bit words (removed slots and used
// slots) are loaded one word per transfer; a query walks outward word by word
// from the word of middle_index and returns the available slot nearest to
// middle_index in the first outward step that holds one, ties to the lower slot,
// or found = 0. After reset a clearing pass zeroes both bitmaps, one word per
// cycle, before the first input transfer is taken; slot_count writes are taken
// at any time. Each cycle of a query the search reads one left and one right
// word through the two read ports of the bitmap memories. A query whose result
// finds the output register still full holds until that result is transferred.
// Input is taken again while a result waits in the output register.
module nearest_free_slot_search #(
	parameter int MAX_SLOTS = nfs_pkg::MAX_SLOTS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  nfs_pkg::in_t                in_data,
	output logic                        out_valid,
	input  logic                        out_ready,
	output nfs_pkg::out_t               out_data,
	input  logic                        cfg_wen,
	input  logic [nfs_pkg::CNT_W-1:0]   cfg_wdata
);
	import nfs_pkg::*;

	cmd_t    cmd;
	status_t status;

	nfs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_kind   (in_data.kind),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.status    (status)
	);

	nfs_dp #(
		.MAX_SLOTS (MAX_SLOTS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.in_data   (in_data),
		.cmd       (cmd),
		.status    (status),
		.out_data  (out_data)
	);

endmodule

>>> hw/rtl/nfs_ctrl.sv
// Controller state machine for the nearest free slot search block.
// Depends on nfs_pkg; drives nfs_dp through cmd_t and reads status_t.
module nfs_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  nfs_pkg::kind_t    in_kind,
	output logic              out_valid,
	input  logic              out_ready,
	output nfs_pkg::cmd_t     cmd,
	input  nfs_pkg::status_t  status
);
	import nfs_pkg::*;

	state_t state_q;
	state_t state_next;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cmd.push) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (status.clear_last) state_next = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid && in_kind == KIND_QUERY) state_next = ST_SEARCH;
			end
			ST_SEARCH: begin
				if (status.done) state_next = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) state_next = ST_IDLE;
			end
			default: state_next = ST_CLEAR;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clear = 1'b1;
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					case (in_kind)
						KIND_LOAD_REMOVED: cmd.load_removed = 1'b1;
						KIND_LOAD_USED:    cmd.load_used    = 1'b1;
						KIND_QUERY:        cmd.start        = 1'b1;
						default:           ;
					endcase
				end
			end
			ST_SEARCH: begin
				// keep reading ahead; the evaluated step is the one read in the previous cycle
				cmd.step    = 1'b1;
				cmd.capture = status.done;
			end
			ST_DONE: begin
				cmd.push = out_free;
			end
			default: ;
		endcase
	end

endmodule

>>> hw/rtl/nfs_dp.sv
// Datapath for the nearest free slot search block: bitmap memories, slot
// count register, outward word walk and the result registers. Depends on nfs_pkg.
module nfs_dp #(
	parameter int MAX_SLOTS = nfs_pkg::MAX_SLOTS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wen,
	input  logic [nfs_pkg::CNT_W-1:0]   cfg_wdata,
	input  nfs_pkg::in_t                in_data,
	input  nfs_pkg::cmd_t               cmd,
	output nfs_pkg::status_t            status,
	output nfs_pkg::out_t               out_data
);
	import nfs_pkg::*;

	localparam int NWORDS = MAX_SLOTS / WORD_W;
	localparam int AW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
	localparam int IW     = (AW + 1 > 7) ? AW + 1 : 7;
	localparam int WW     = IW + 1;
	localparam int MW     = WW + BIT_W;
	localparam int CW     = ($clog2(MAX_SLOTS + 1) > CNT_W) ? $clog2(MAX_SLOTS + 1) : CNT_W;

	function automatic logic [BIT_W-1:0] low_idx(input logic [WORD_W-1:0] v);
		logic [WORD_W-1:0] iso;
		logic [BIT_W-1:0]  r;
		iso = v & (~v + WORD_W'(1));
		r   = '0;
		for (int k = 0; k < WORD_W; k++) begin
			if (iso[k]) r = r | BIT_W'(k);
		end
		return r;
	endfunction

	function automatic logic [BIT_W-1:0] high_idx(input logic [WORD_W-1:0] v);
		logic [WORD_W-1:0] rev;
		for (int k = 0; k < WORD_W; k++) begin
			rev[k] = v[WORD_W-1-k];
		end
		return BIT_W'(WORD_W - 1) - low_idx(rev);
	endfunction

	// slots of word w that lie below the slot count
	function automatic logic [WORD_W-1:0] word_mask(input logic [CW-1:0] cnt,
			input logic [WW-1:0] w);
		logic [MW-1:0]     base;
		logic [MW-1:0]     n;
		logic [WORD_W-1:0] m;
		base = {w, {BIT_W{1'b0}}};
		n    = MW'(cnt) - base;
		if (MW'(cnt) <= base) begin
			m = '0;
		end else if (n >= MW'(WORD_W)) begin
			m = '1;
		end else begin
			m = (WORD_W'(1) << n[BIT_W-1:0]) - WORD_W'(1);
		end
		return m;
	endfunction

	logic [WORD_W-1:0] removed_mem [NWORDS];
	logic [WORD_W-1:0] used_mem [NWORDS];

	logic [CNT_W-1:0]  slot_count_q;
	logic [AW-1:0]     clear_idx_q;

	logic [WW-1:0]     pack_q;
	logic [BIT_W-1:0]  within_q;
	logic [CW-1:0]     cnt_q;
	logic [WW-1:0]     lim_q;
	logic [IW-1:0]     step_idx_q;

	logic              valid_s1;
	logic              center_s1;
	logic              lvld_s1;
	logic              lin_s1;
	logic              rvld_s1;
	logic [WW-1:0]     lword_s1;
	logic [WW-1:0]     rword_s1;
	logic [WORD_W-1:0] rem_l_s1;
	logic [WORD_W-1:0] used_l_s1;
	logic [WORD_W-1:0] rem_r_s1;
	logic [WORD_W-1:0] used_r_s1;

	out_t              res_q;
	out_t              out_q;

	// write port shared by the clearing pass and the loads
	logic              wr_ok;
	logic [AW-1:0]     wr_addr;
	logic [WORD_W-1:0] wr_data;
	logic              rem_we;
	logic              used_we;

	assign wr_ok   = 32'(in_data.word_index) < 32'(NWORDS);
	assign wr_addr = cmd.clear ? clear_idx_q : AW'(in_data.word_index);
	assign wr_data = cmd.clear ? '0 : in_data.word_data;
	assign rem_we  = cmd.clear || (cmd.load_removed && wr_ok);
	assign used_we = cmd.clear || (cmd.load_used && wr_ok);

	assign status.clear_last = clear_idx_q == AW'(NWORDS - 1);

	// query setup
	logic [CW-1:0]     cnt_eff;
	logic [CW:0]       lim_sum;

	assign cnt_eff = (CW'(slot_count_q) > CW'(MAX_SLOTS)) ? CW'(MAX_SLOTS) : CW'(slot_count_q);
	assign lim_sum = {1'b0, cnt_eff} + (CW + 1)'(WORD_W - 1);

	// read side of one outward step
	logic [WW-1:0]     lword_rd;
	logic [WW-1:0]     rword_rd;
	logic              center_rd;
	logic              lvld_rd;
	logic              lin_rd;
	logic              rvld_rd;

	assign center_rd = step_idx_q == '0;
	assign lword_rd  = pack_q - WW'(step_idx_q);
	assign rword_rd  = pack_q + WW'(step_idx_q);
	assign lvld_rd   = pack_q >= WW'(step_idx_q);
	assign lin_rd    = lword_rd < WW'(NWORDS);
	assign rvld_rd   = !center_rd && (rword_rd < lim_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_count_q <= '0;
			clear_idx_q  <= '0;
			valid_s1     <= 1'b0;
		end else begin
			if (cfg_wen) slot_count_q <= cfg_wdata;
			if (cmd.clear) clear_idx_q <= clear_idx_q + AW'(1);
			valid_s1 <= cmd.step;
		end
	end

	always_ff @(posedge clk) begin
		if (rem_we) removed_mem[wr_addr] <= wr_data;
		if (used_we) used_mem[wr_addr] <= wr_data;
		rem_l_s1  <= removed_mem[lword_rd[AW-1:0]];
		used_l_s1 <= used_mem[lword_rd[AW-1:0]];
		rem_r_s1  <= removed_mem[rword_rd[AW-1:0]];
		used_r_s1 <= used_mem[rword_rd[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			pack_q     <= WW'(in_data.middle_index[SLOT_W-1:BIT_W]);
			within_q   <= in_data.middle_index[BIT_W-1:0];
			cnt_q      <= cnt_eff;
			lim_q      <= WW'(lim_sum >> BIT_W);
			step_idx_q <= '0;
		end else if (cmd.step) begin
			step_idx_q <= step_idx_q + IW'(1);
		end
		if (cmd.step) begin
			center_s1 <= center_rd;
			lvld_s1   <= lvld_rd;
			lin_s1    <= lin_rd;
			rvld_s1   <= rvld_rd;
			lword_s1  <= lword_rd;
			rword_s1  <= rword_rd;
		end
	end

	// evaluate the words read in the previous cycle
	logic [WORD_W-1:0] l_av;
	logic [WORD_W-1:0] r_av;
	logic [WORD_W-1:0] below;
	logic [WORD_W-1:0] lcand;
	logic [WORD_W-1:0] rcand;
	logic [WW-1:0]     rword_sel;
	logic [BIT_W-1:0]  hb;
	logic [BIT_W-1:0]  lb;
	logic              take_r;
	logic              hit;
	logic              exhausted;
	out_t              res_d;

	assign l_av = (lvld_s1 && lin_s1) ?
		(~(rem_l_s1 | used_l_s1) & word_mask(cnt_q, lword_s1)) : '0;
	assign r_av = rvld_s1 ?
		(~(rem_r_s1 | used_r_s1) & word_mask(cnt_q, rword_s1)) : '0;
	assign below = (WORD_W'(1) << within_q) - WORD_W'(1);

	// the middle word splits at the middle slot, which counts as above
	assign lcand     = center_s1 ? (l_av & below) : l_av;
	assign rcand     = center_s1 ? (l_av & ~below) : r_av;
	assign rword_sel = center_s1 ? lword_s1 : rword_s1;
	assign hb        = high_idx(lcand);
	assign lb        = low_idx(rcand);

	// right wins only when strictly nearer: lb + hb < 2 * within
	assign take_r    = (rcand != '0) &&
		((lcand == '0) || (({1'b0, lb} + {1'b0, hb}) < {within_q, 1'b0}));
	assign hit       = (lcand | rcand) != '0;
	assign exhausted = !center_s1 && !lvld_s1 && !rvld_s1;

	always_comb begin
		res_d.found      = hit;
		res_d.slot_index = '0;
		if (hit) begin
			res_d.slot_index = take_r ? {rword_sel[BIT_W-1:0], lb} : {lword_s1[BIT_W-1:0], hb};
		end
	end

	assign status.done = valid_s1 && (hit || exhausted);

	always_ff @(posedge clk) begin
		if (cmd.capture) res_q <= res_d;
		if (cmd.push) out_q <= res_q;
	end

	assign out_data = out_q;

endmodule
